>>> design/rbf_pkg.sv
`default_nettype none

package rbf_pkg;

    localparam int CHANNELS          = 3;
    localparam int CHAN_W            = 8;
    localparam int PIX_W             = CHANNELS * CHAN_W;
    localparam int SUM_W             = 12;
    localparam int RECIP_W           = 13;
    localparam int RECIP_SHIFT       = 16;
    localparam int DEFAULT_MAX_WIDTH = 2048;

    localparam int IMAGE_WIDTH_W     = 12;
    localparam int IMAGE_HEIGHT_W    = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_INDEX_W       = 1;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam logic [SUM_W-1:0]   ROUND_BIAS = 12'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [CHANNELS-1:0] pixel_t;
    typedef pixel_t [2:0] column_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [CHANNELS-1:0] sums_t;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } stage_ctrl_t;

endpackage

`default_nettype wire

>>> design/rbf_ram.sv
`default_nettype none

module rbf_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/rbf_window.sv
`default_nettype none

module rbf_window (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 clear,
    input  wire rbf_pkg::stage_ctrl_t s1_ctrl,
    input  wire rbf_pkg::column_t     col,
    output rbf_pkg::stage_ctrl_t      s2_ctrl,
    output rbf_pkg::sums_t            s2_sums
);

    import rbf_pkg::*;

    column_t     win0_reg;
    column_t     win1_reg;
    stage_ctrl_t s2_ctrl_reg;
    sums_t       s2_sums_reg;
    sums_t       sums_next;

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            sums_next[ch] = '0;
            for (int k = 0; k < 3; k++)
            begin
                sums_next[ch] = sums_next[ch] + SUM_W'(col[k][ch])
                              + SUM_W'(win0_reg[k][ch]) + SUM_W'(win1_reg[k][ch]);
            end
        end
    end

    // shift the window on every transaction leaving the input stage; a register write clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            s2_ctrl_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                win0_reg <= '0;
                win1_reg <= '0;
            end
            else if (advance && s1_ctrl.valid)
            begin
                win0_reg <= col;
                win1_reg <= win0_reg;
            end
            if (advance)
            begin
                s2_ctrl_reg <= s1_ctrl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sums_reg <= sums_next;
        end
    end

    assign s2_ctrl = s2_ctrl_reg;
    assign s2_sums = s2_sums_reg;

endmodule

`default_nettype wire

>>> design/rbf_mean.sv
`default_nettype none

module rbf_mean (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire rbf_pkg::stage_ctrl_t s2_ctrl,
    input  wire rbf_pkg::sums_t       s2_sums,
    output logic                      out_valid,
    output rbf_pkg::pixel_t           out_pixel,
    output logic                      out_last
);

    import rbf_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic   out_valid_reg;
    logic   out_last_reg;
    pixel_t out_pixel_reg;
    pixel_t mean_next;
    logic [PROD_W-1:0] prod [CHANNELS];

    // round(sum / 9) as floor((sum + 4) * 7282 / 2^16), exact over the sum range
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            prod[ch]      = PROD_W'(s2_sums[ch] + ROUND_BIAS) * PROD_W'(RECIP_NINE);
            mean_next[ch] = prod[ch][RECIP_SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s2_ctrl.valid && s2_ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pixel_reg <= mean_next;
            out_last_reg  <= s2_ctrl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> design/rgb_box_filter_3x3.sv
`default_nettype none

// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   s_tdata: red, green, blue
// m_        out  m_tvalid / m_tready   m_tdata: red, green, blue; m_tlast: frame_last
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock sustained while m_ does not stall.
// The line stores are single-write RAMs read at acceptance, written as the pixel
// leaves the input stage; the window and the divide-by-nine stage follow.
// Reset restores 640x480 and empties the pipeline; a register write restarts the frame.
// A stall at m_ holds every stage and drops s_tready in the same cycle.
module rgb_box_filter_3x3 #(
    parameter int MAX_WIDTH = rbf_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rbf_pkg::PIX_W-1:0]          s_tdata,   // red, green, blue
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [rbf_pkg::PIX_W-1:0]          m_tdata,   // red, green, blue
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rbf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rbf_pkg::*;

    localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WU_W  = CNT_W + 1;
    localparam int CMP_W = (WU_W > IMAGE_WIDTH_W) ? WU_W : IMAGE_WIDTH_W;

    logic [IMAGE_WIDTH_W-1:0]  image_width_reg;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg;
    logic [CNT_W-1:0]          col_cnt_reg;
    logic [CNT_W-1:0]          col_cnt_next;
    logic [IMAGE_HEIGHT_W-1:0] row_cnt_reg;
    logic [IMAGE_HEIGHT_W-1:0] row_cnt_next;

    logic [CMP_W-1:0]          width_ext;
    logic [WU_W-1:0]           width_use;
    logic [CNT_W-1:0]          last_col;
    logic [IMAGE_HEIGHT_W-1:0] height_use;
    logic [IMAGE_HEIGHT_W-1:0] last_row;
    logic                      col_last;
    logic                      row_last;

    logic        cfg_write;
    logic        stall;
    logic        advance;
    logic        in_accept;

    stage_ctrl_t s1_ctrl_reg;
    stage_ctrl_t s1_ctrl_next;
    pixel_t      s1_pix_reg;
    logic [CNT_W-1:0] s1_col_reg;
    logic        line_wr;
    pixel_t      one_above;
    pixel_t      two_above;
    column_t     col;

    stage_ctrl_t s2_ctrl;
    sums_t       s2_sums;
    pixel_t      out_pixel;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMAGE_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMAGE_HEIGHT_W-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        width_ext = CMP_W'(image_width_reg);
        if (width_ext < CMP_W'(3))
        begin
            width_use = WU_W'(3);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            width_use = WU_W'(MAX_WIDTH);
        end
        else
        begin
            width_use = WU_W'(width_ext);
        end
        if (image_height_reg < IMAGE_HEIGHT_W'(3))
        begin
            height_use = IMAGE_HEIGHT_W'(3);
        end
        else
        begin
            height_use = image_height_reg;
        end
    end

    assign last_col = CNT_W'(width_use - WU_W'(1));
    assign last_row = height_use - IMAGE_HEIGHT_W'(1);
    assign col_last = (col_cnt_reg == last_col);
    assign row_last = (row_cnt_reg == last_row);

    assign stall     = m_tvalid && !m_tready;
    assign advance   = !stall;
    assign s_tready  = advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        col_cnt_next = col_cnt_reg + CNT_W'(1);
        row_cnt_next = row_cnt_reg;
        if (col_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_last ? '0 : row_cnt_reg + IMAGE_HEIGHT_W'(1);
        end
    end

    always_comb
    begin
        s1_ctrl_next.valid = in_accept;
        s1_ctrl_next.emit  = (row_cnt_reg >= IMAGE_HEIGHT_W'(2)) && (col_cnt_reg >= CNT_W'(2));
        s1_ctrl_next.last  = row_last && col_last;
    end

    // advance the frame position on each input transaction; a register write restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end
            else if (in_accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (advance)
            begin
                s1_ctrl_reg <= s1_ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg <= pixel_t'(s_tdata);
            s1_col_reg <= col_cnt_reg;
        end
    end

    assign line_wr = advance && s1_ctrl_reg.valid;

    rbf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .ADDR_W(CNT_W)
    ) u_line_one (
        .clk    (clk),
        .wr_en  (line_wr),
        .wr_addr(s1_col_reg),
        .wr_data(s1_pix_reg),
        .rd_en  (in_accept),
        .rd_addr(col_cnt_reg),
        .rd_data(one_above)
    );

    rbf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .ADDR_W(CNT_W)
    ) u_line_two (
        .clk    (clk),
        .wr_en  (line_wr),
        .wr_addr(s1_col_reg),
        .wr_data(one_above),
        .rd_en  (in_accept),
        .rd_addr(col_cnt_reg),
        .rd_data(two_above)
    );

    assign col[0] = two_above;
    assign col[1] = one_above;
    assign col[2] = s1_pix_reg;

    rbf_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .clear  (cfg_write),
        .s1_ctrl(s1_ctrl_reg),
        .col    (col),
        .s2_ctrl(s2_ctrl),
        .s2_sums(s2_sums)
    );

    rbf_mean u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s2_ctrl  (s2_ctrl),
        .s2_sums  (s2_sums),
        .out_valid(m_tvalid),
        .out_pixel(out_pixel),
        .out_last (m_tlast)
    );

    assign m_tdata = PIX_W'(out_pixel);

endmodule

`default_nettype wire

>>> test/rgb_box_filter_3x3_tb.sv
`default_nettype none

module rgb_box_filter_3x3_tb;

    import rbf_pkg::*;

    localparam int MAX_W         = DEFAULT_MAX_WIDTH;
    localparam int LATENCY_PAUSE = 8;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 960;
    localparam int RUN_CAP       = 200;
    localparam int WIDE_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 500;
    localparam int DIR_ROWS      = 27;

    // red [7:0], green [15:8], blue [23:16]
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  last;
    } mean_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  typed;
        mean_t want;
    } dir_row_t;

    localparam mean_t NO_WANT = '0;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b0, NO_WANT},
        '{8'd255, 8'd0,   8'd128, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b1}},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b0, NO_WANT},
        '{8'd0,   8'd255, 8'd127, 1'b1, '{8'd0, 8'd255, 8'd127, 1'b1}},
        '{8'd5,   8'd4,   8'd13,  1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT},
        '{8'd0,   8'd0,   8'd0,   1'b0, NO_WANT}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;   // red, green, blue
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;          // red, green, blue
    logic                  m_tlast;          // frame_last
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  hold_off    = 1'b0;
    bit                    pressure_go = 1'b0;

    bit   [PIX_W-1:0]          row_above     [MAX_W];
    bit   [PIX_W-1:0]          row_two_above [MAX_W];
    pix_t                      win_prev      [3];
    pix_t                      win_prev2     [3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [IMAGE_WIDTH_W-1:0]  width_reg  = IMAGE_WIDTH_RESET;
    logic [IMAGE_HEIGHT_W-1:0] height_reg = IMAGE_HEIGHT_RESET;

    mean_t       means_due [$];
    int          errors;
    int unsigned cycle;

    rgb_box_filter_3x3 #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic chan_t channel(input pix_t px, input int ch);
        return px[CHAN_W*ch +: CHAN_W];
    endfunction

    function automatic pix_t rand_pixel();
        pix_t px;
        int   roll;
        px = pix_t'($urandom);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                px[CHAN_W*ch +: CHAN_W] = '1;
            else if (roll == 1)
                px[CHAN_W*ch +: CHAN_W] = '0;
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic filter_pixel(input pix_t px, output bit emitted, output mean_t mean);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned sum;
        pix_t        col [3];
        chan_t       avg [3];
        w = 32'(width_reg);
        if (w < 3)
            w = 3;
        if (w > MAX_W)
            w = MAX_W;
        h = 32'(height_reg);
        if (h < 3)
            h = 3;
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        col[0] = row_two_above[c];
        col[1] = row_above[c];
        col[2] = px;
        emitted = (r >= 2) && (c >= 2);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                sum += 32'(channel(col[k], ch));
                sum += 32'(channel(win_prev[k], ch));
                sum += 32'(channel(win_prev2[k], ch));
            end
            avg[ch] = chan_t'((sum + 4) / 9);
        end
        mean = '{avg[0], avg[1], avg[2], (r == h - 1) && (c == w - 1)};
        row_two_above[c] = col[1];
        row_above[c]     = px;
        win_prev2 = win_prev;
        win_prev  = col;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic write_sizes(input logic [CFG_DATA_W-1:0] width_val,
                               input logic [CFG_DATA_W-1:0] height_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= width_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= height_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg  = width_val[IMAGE_WIDTH_W-1:0];
        height_reg = height_val;
        col_pos    = 0;
        row_pos    = 0;
        for (int k = 0; k < 3; k++)
        begin
            win_prev[k]  = '0;
            win_prev2[k] = '0;
        end
    endtask

    task automatic send_pixel(input pix_t px, input bit typed, input mean_t want,
                              input bit steady);
        int    gap;
        bit    emitted;
        mean_t mean;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        filter_pixel(px, emitted, mean);
        if (emitted)
            means_due.push_back(typed ? want : mean);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (means_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("rgb_box_filter_3x3: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver_hold
        int held;
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : result_sink
        mean_t     got;
        mean_t     want;
        static int stall_left  = 0;
        static int mode_left   = 0;
        static bit sink_steady = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[CHAN_W-1:0], m_tdata[2*CHAN_W-1:CHAN_W],
                        m_tdata[3*CHAN_W-1:2*CHAN_W], m_tlast};
                if (means_due.size() == 0)
                    report_mismatch("result with no pending pixel", int'(got), -1);
                else
                begin
                    want = means_due.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red", int'(got.red), int'(want.red));
                    if (got.green !== want.green)
                        report_mismatch("green", int'(got.green), int'(want.green));
                    if (got.blue !== want.blue)
                        report_mismatch("blue", int'(got.blue), int'(want.blue));
                    if (got.last !== want.last)
                        report_mismatch("frame_last", int'(got.last), int'(want.last));
                end
            end
            if (mode_left == 0)
            begin
                sink_steady = ($urandom_range(0, 3) == 0);
                mode_left   = $urandom_range(50, 300);
            end
            else
                mode_left--;
            if (stall_left > 0)
                stall_left--;
            else if (!sink_steady)
                stall_left = pick_gap();
            m_tready <= !hold_off && (stall_left == 0);
        end
    end

    initial
    begin : stimulus
        int                    sent;
        int                    n;
        int                    w;
        int                    h;
        int                    frame;
        int                    roll;
        bit                    steady;
        dir_row_t              row;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_sizes(16'd0, 16'd2);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            send_pixel({row.blue, row.green, row.red}, row.typed, row.want, 1'b0);
        end
        drain();

        // stall the output long enough to back up the input
        write_sizes(16'd6, 16'd5);
        pressure_go = 1'b1;
        for (n = 0; n < 300; n++)
            send_pixel(rand_pixel(), 1'b0, NO_WANT, 1'b0);
        sent += 300;
        drain();

        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
                w = $urandom_range(3, 12);
            else if (roll < 9)
                w = $urandom_range(0, 2);
            else
                w = $urandom_range(13, 40);
            roll = $urandom_range(0, 9);
            if (roll < 6)
                h = $urandom_range(3, 8);
            else if (roll < 8)
                h = $urandom_range(0, 2);
            else if (roll < 9)
                h = 65535;
            else
                h = $urandom_range(9, 300);
            wv = {4'($urandom), 12'(w)};
            hv = 16'(h);
            if (w < 3)
                w = 3;
            if (h < 3)
                h = 3;
            frame = w * h;
            if (h <= 8)
                n = frame * $urandom_range(1, 3) + $urandom_range(0, frame);
            else
                n = $urandom_range(3 * w, 8 * w);
            if (n > RUN_CAP)
                n = RUN_CAP;
            write_sizes(wv, hv);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++)
                send_pixel(rand_pixel(), 1'b0, NO_WANT, steady);
            sent += n;
            drain();
        end

        write_sizes(16'hFFFF, 16'hFFFF);
        for (n = 0; n < WIDE_ITEMS; n++)
            send_pixel(rand_pixel(), 1'b0, NO_WANT, 1'b0);
        drain();

        if (errors == 0 && means_due.size() == 0)
            $display("rgb_box_filter_3x3: match");
        else
            $display("rgb_box_filter_3x3: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/rbf_pkg.sv
design/rbf_ram.sv
design/rbf_window.sv
design/rbf_mean.sv
design/rgb_box_filter_3x3.sv
test/rgb_box_filter_3x3_tb.sv
